### rtl/bhtt_pkg.sv
// ============================================================================
// bhtt_pkg
// Shared types and constants for the button hold / trigger / toggle block.
// ============================================================================
package bhtt_pkg;

    // Sizes of the counter banks
    localparam int PAD_SLOTS   = 16;
    localparam int MAPPED_KEYS = 14;
    localparam int COUNT_BITS  = 31;

    // Field widths of one input beat, the key map and the answer
    localparam int PAD_W    = 16;
    localparam int KEY_W    = 14;
    localparam int HANDLE_W = 8;
    localparam int MODE_W   = 2;
    localparam int MAP_FIELD_W = 4;
    localparam int MAP_W    = MAP_FIELD_W * MAPPED_KEYS;
    localparam int ANSWER_W = 32;

    localparam int IN_FIELDS_W = PAD_W + KEY_W + HANDLE_W + MODE_W;
    localparam int S_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((ANSWER_W + 7) / 8) * 8;

    // Slot index width
    localparam int SLOT_W = (PAD_SLOTS > 1) ? $clog2(PAD_SLOTS) : 1;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = MAP_W;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTION_MAP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_ENABLE = 2'd1;

    localparam logic [KEY_W-1:0] KEY_ENABLE_RESET = '1;

    // Request kinds carried in tuser
    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH    = 2'd0,
        MODE_TRIGGER = 2'd1,
        MODE_TOGGLE  = 2'd2,
        MODE_ZERO    = 2'd3
    } mode_t;

    typedef logic [COUNT_BITS-1:0] count_t;
    typedef count_t [PAD_SLOTS-1:0]   slot_cnt_t;
    typedef count_t [MAPPED_KEYS-1:0] key_cnt_t;

    localparam count_t COUNT_MAX = '1;

    // Saturating increment
    function automatic count_t bump(input count_t c);
        count_t r;
        r = (c == COUNT_MAX) ? c : c + count_t'(1);
        return r;
    endfunction

endpackage

### rtl/bhtt_tick.sv
// ============================================================================
// bhtt_tick
// Next-state logic of the hold counters for one frame tick: key and slot
// counters count up or clear, then each slot takes the max of its own count
// and every enabled key mapped to it (registered upstream and downstream).
// ============================================================================
module bhtt_tick (
    input  bhtt_pkg::slot_cnt_t                 slot_cnt,
    input  bhtt_pkg::key_cnt_t                  key_cnt,
    input  logic [bhtt_pkg::PAD_W-1:0]          pad_bits,
    input  logic [bhtt_pkg::KEY_W-1:0]          key_bits,
    input  logic [bhtt_pkg::MAP_W-1:0]          action_map,
    input  logic [bhtt_pkg::KEY_W-1:0]          key_enable,
    output bhtt_pkg::slot_cnt_t                 slot_cnt_next,
    output bhtt_pkg::key_cnt_t                  key_cnt_next
);
    import bhtt_pkg::*;

    // Own count plus one leaf per key, padded to a power of two
    localparam int LEAVES = MAPPED_KEYS + 1;
    localparam int LEVELS = (LEAVES > 1) ? $clog2(LEAVES) : 1;
    localparam int WIDTH  = 2 ** LEVELS;

    count_t tree [PAD_SLOTS][LEVELS+1][WIDTH];
    logic [MAPPED_KEYS-1:0] hit [PAD_SLOTS];

    // Count up or clear the key counters
    always_comb
    begin
        for (int k = 0; k < MAPPED_KEYS; k++)
        begin
            key_cnt_next[k] = key_bits[k] ? bump(key_cnt[k]) : '0;
        end
    end

    // Decode which enabled keys merge into each slot
    always_comb
    begin
        for (int s = 0; s < PAD_SLOTS; s++)
        begin
            for (int k = 0; k < MAPPED_KEYS; k++)
            begin
                hit[s][k] = key_enable[k] &&
                    ({1'b0, action_map[k*MAP_FIELD_W +: MAP_FIELD_W]} ==
                     (MAP_FIELD_W+1)'(s));
            end
        end
    end

    // Max tree per slot over its own new count and its mapped keys
    always_comb
    begin
        for (int s = 0; s < PAD_SLOTS; s++)
        begin
            for (int j = 0; j < WIDTH; j++)
            begin
                if (j < MAPPED_KEYS)
                begin
                    tree[s][0][j] = hit[s][j] ? key_cnt_next[j] : '0;
                end
                else if (j == MAPPED_KEYS)
                begin
                    tree[s][0][j] = pad_bits[s] ? bump(slot_cnt[s]) : '0;
                end
                else
                begin
                    tree[s][0][j] = '0;
                end
            end
            for (int l = 1; l <= LEVELS; l++)
            begin
                for (int j = 0; j < WIDTH; j++)
                begin
                    if (j < (WIDTH >> l))
                    begin
                        tree[s][l][j] = (tree[s][l-1][2*j] > tree[s][l-1][2*j+1]) ?
                                        tree[s][l-1][2*j] : tree[s][l-1][2*j+1];
                    end
                    else
                    begin
                        tree[s][l][j] = '0;
                    end
                end
            end
            slot_cnt_next[s] = tree[s][LEVELS][0];
        end
    end

endmodule

### rtl/button_hold_trigger_toggle.sv
// ============================================================================
// button_hold_trigger_toggle
// Hold counters for pad slots and mapped keyboard keys, with push, release
// trigger and toggle queries on one slot.
// ============================================================================
//  Channel  | Dir | Beat contents
//  s_axis   | in  | tuser: req_type; tdata: pad_bits, key_bits, slot_handle,
//           |     |        query_mode (lowest bit up)
//  m_axis   | out | tdata: answer (signed, 32 bits); one beat per query
//  cfg      | in  | cfg_index 0 action_map, 1 key_enable; cfg_data value
//
//  One item per cycle sustained while answers are not stalled. A beat lands
//  in an input register, then one pass of logic updates the counters or
//  answers the query into the output register. A query waits in the input
//  register while the output beat is stalled; ticks go through regardless.
//  Reset clears all counters, trigger and toggle flags, action_map to zero
//  and key_enable to all ones.
// ============================================================================
module button_hold_trigger_toggle (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [15:0] pad_bits, [29:16] key_bits, [37:30] slot_handle, [39:38] query_mode
    input  logic [bhtt_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    // [0] req_type
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [31:0] answer
    output logic [bhtt_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bhtt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bhtt_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import bhtt_pkg::*;

    localparam int KEY_LSB    = PAD_W;
    localparam int HANDLE_LSB = KEY_LSB + KEY_W;
    localparam int MODE_LSB   = HANDLE_LSB + HANDLE_W;

    // Configuration registers
    logic [MAP_W-1:0]  map_reg;
    logic [KEY_W-1:0]  enable_reg;

    // Input stage
    logic                 in_vld_reg;
    logic                 in_type_reg;
    logic [PAD_W-1:0]     in_pad_reg;
    logic [KEY_W-1:0]     in_key_reg;
    logic [HANDLE_W-1:0]  in_handle_reg;
    logic [MODE_W-1:0]    in_mode_reg;

    // Block state
    slot_cnt_t              slot_cnt_reg;
    key_cnt_t               key_cnt_reg;
    logic [PAD_SLOTS-1:0]   armed_reg;
    logic [PAD_SLOTS-1:0]   toggle_reg;
    logic [PAD_SLOTS-1:0]   armed_next;
    logic [PAD_SLOTS-1:0]   toggle_next;
    slot_cnt_t              slot_cnt_next;
    key_cnt_t               key_cnt_next;

    // Output stage
    logic                 out_vld_reg;
    logic [ANSWER_W-1:0]  out_data_reg;
    logic [ANSWER_W-1:0]  answer_next;

    logic        out_free;
    logic        step_en;
    logic        is_tick;
    logic        slot_ok;
    logic [SLOT_W-1:0] sidx;
    mode_t       mode;
    count_t      cnt;
    logic        armed;
    logic        on;
    logic        fired;

    assign cfg_ready = 1'b1;

    // Handshake: a tick never needs the output, a query needs a free output
    assign is_tick       = (in_type_reg == REQ_TICK);
    assign out_free      = !out_vld_reg || m_axis_tready;
    assign step_en       = in_vld_reg && (is_tick || out_free);
    assign s_axis_tready = !in_vld_reg || step_en;

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = M_TDATA_W'(out_data_reg);

    // Tick next-state logic
    bhtt_tick u_tick (
        .slot_cnt      (slot_cnt_reg),
        .key_cnt       (key_cnt_reg),
        .pad_bits      (in_pad_reg),
        .key_bits      (in_key_reg),
        .action_map    (map_reg),
        .key_enable    (enable_reg),
        .slot_cnt_next (slot_cnt_next),
        .key_cnt_next  (key_cnt_next)
    );

    // Query: read one slot; trigger and toggle modes step its flags
    always_comb
    begin
        mode        = mode_t'(in_mode_reg);
        slot_ok     = (in_handle_reg < HANDLE_W'(PAD_SLOTS));
        sidx        = in_handle_reg[SLOT_W-1:0];
        cnt         = slot_ok ? slot_cnt_reg[sidx] : '0;
        armed       = slot_ok ? armed_reg[sidx] : 1'b0;
        on          = slot_ok ? toggle_reg[sidx] : 1'b0;
        fired       = armed && (cnt == '0);
        armed_next  = armed_reg;
        toggle_next = toggle_reg;
        answer_next = '0;
        case (mode)
            MODE_PUSH:
            begin
                answer_next = slot_ok ? ANSWER_W'(cnt) : '1;
            end
            MODE_TRIGGER:
            begin
                if (slot_ok)
                begin
                    armed_next[sidx] = (cnt != '0);
                    answer_next      = ANSWER_W'(fired);
                end
                else
                begin
                    answer_next = '1;
                end
            end
            MODE_TOGGLE:
            begin
                if (slot_ok)
                begin
                    armed_next[sidx]  = (cnt != '0);
                    toggle_next[sidx] = on ^ fired;
                    answer_next       = (on ^ fired) ? ANSWER_W'(cnt) : '0;
                end
                else
                begin
                    answer_next = '1;
                end
            end
            default:
            begin
                answer_next = '0;
            end
        endcase
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_reg    <= '0;
            enable_reg <= KEY_ENABLE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ACTION_MAP: map_reg    <= cfg_data[MAP_W-1:0];
                CFG_KEY_ENABLE: enable_reg <= cfg_data[KEY_W-1:0];
                default:        ;
            endcase
        end
    end

    // Input stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_vld_reg <= s_axis_tvalid;
        end
    end

    // Input stage payload
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_type_reg   <= s_axis_tuser;
            in_pad_reg    <= s_axis_tdata[PAD_W-1:0];
            in_key_reg    <= s_axis_tdata[KEY_LSB +: KEY_W];
            in_handle_reg <= s_axis_tdata[HANDLE_LSB +: HANDLE_W];
            in_mode_reg   <= s_axis_tdata[MODE_LSB +: MODE_W];
        end
    end

    // Counters and flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_cnt_reg <= '0;
            key_cnt_reg  <= '0;
            armed_reg    <= '0;
            toggle_reg   <= '0;
        end
        else if (step_en)
        begin
            if (is_tick)
            begin
                slot_cnt_reg <= slot_cnt_next;
                key_cnt_reg  <= key_cnt_next;
            end
            else
            begin
                armed_reg  <= armed_next;
                toggle_reg <= toggle_next;
            end
        end
    end

    // Output stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (step_en && !is_tick)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    // Output stage payload
    always_ff @(posedge clk)
    begin
        if (step_en && !is_tick)
        begin
            out_data_reg <= answer_next;
        end
    end

endmodule

### tb/sv/tb_button_hold_trigger_toggle.sv
// ============================================================================
// tb_button_hold_trigger_toggle
// Self-checking bench for the button hold / trigger / toggle block. A
// scoreboard class keeps its own copy of the hold counters, trigger and
// toggle flags and the key map. Every accepted query beat queues the answer
// it predicts, and every answer beat is checked against the oldest one.
// Directed beats open the run. Random phases follow, each with its own key
// map and enable setting and its own mix of sender gaps and receiver stalls.
// ============================================================================
module tb_button_hold_trigger_toggle;

    import bhtt_pkg::*;

    localparam int CLK_PERIOD      = 20;
    localparam int RESET_CYCLES    = 7;
    localparam int SETTLE_CYCLES   = 10;
    localparam int LIMIT_CYCLES    = 200_000;
    localparam int PHASE_ITEMS     = 113;
    localparam int LONG_HOLD_OFF   = 300;
    localparam int QUERY_PCT       = 55;
    localparam int GOOD_HANDLE_PCT = 85;

    // Register indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    // ------------------------------------------------------------------------
    // Scoreboard: counter and flag state plus the queue of answers due
    // ------------------------------------------------------------------------
    class hold_scoreboard;
        count_t              slot_count [PAD_SLOTS];
        count_t              key_count [MAPPED_KEYS];
        bit                  armed [PAD_SLOTS];
        bit                  toggle_state [PAD_SLOTS];
        logic [MAP_W-1:0]    slot_map;
        logic [KEY_W-1:0]    merge_enable;
        logic [ANSWER_W-1:0] answers_due [$];
        int                  errors;

        function new();
            foreach (slot_count[i])
            begin
                slot_count[i]   = '0;
                armed[i]        = 1'b0;
                toggle_state[i] = 1'b0;
            end
            foreach (key_count[k])
                key_count[k] = '0;
            slot_map     = '0;
            merge_enable = KEY_ENABLE_RESET;
            errors       = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_ACTION_MAP: slot_map = value[MAP_W-1:0];
                CFG_KEY_ENABLE: merge_enable = value[KEY_W-1:0];
                default: ;
            endcase
        endfunction

        // Count up one frame, holding at the top
        function count_t hold_one_more(count_t c);
            return (c == COUNT_MAX) ? c : c + count_t'(1);
        endfunction

        // Keys first, then slots from their own bits, then merges in key order
        function void advance_frame(logic [PAD_W-1:0] pads, logic [KEY_W-1:0] keys);
            int target;
            for (int k = 0; k < MAPPED_KEYS; k++)
                key_count[k] = keys[k] ? hold_one_more(key_count[k]) : count_t'(0);
            for (int i = 0; i < PAD_SLOTS; i++)
                slot_count[i] = pads[i] ? hold_one_more(slot_count[i]) : count_t'(0);
            for (int k = 0; k < MAPPED_KEYS; k++)
            begin
                target = int'(slot_map[k*MAP_FIELD_W +: MAP_FIELD_W]);
                if (merge_enable[k] && target < PAD_SLOTS &&
                    key_count[k] > slot_count[target])
                    slot_count[target] = key_count[k];
            end
        endfunction

        // Arm on a held slot, fire once when it is let go
        function bit fire_trigger(int s);
            if (armed[s])
            begin
                if (slot_count[s] != '0)
                    return 1'b0;
                armed[s] = 1'b0;
                return 1'b1;
            end
            if (slot_count[s] != '0)
                armed[s] = 1'b1;
            return 1'b0;
        endfunction

        function logic [ANSWER_W-1:0] answer_query(logic [HANDLE_W-1:0] handle, mode_t mode);
            int                  s;
            bit                  fired;
            logic [ANSWER_W-1:0] count_word;
            if (mode == MODE_ZERO)
                return '0;
            if (int'(handle) >= PAD_SLOTS)
                return '1;
            s = int'(handle);
            count_word = ANSWER_W'(slot_count[s]);
            if (mode == MODE_PUSH)
                return count_word;
            fired = fire_trigger(s);
            if (mode == MODE_TRIGGER)
                return ANSWER_W'(fired);
            // Toggle: each trigger flips the on state
            if (toggle_state[s])
            begin
                if (fired)
                begin
                    toggle_state[s] = 1'b0;
                    return '0;
                end
                return count_word;
            end
            if (fired)
            begin
                toggle_state[s] = 1'b1;
                return count_word;
            end
            return '0;
        endfunction

        function void note_input(logic req, logic [PAD_W-1:0] pads, logic [KEY_W-1:0] keys,
                                 logic [HANDLE_W-1:0] handle, mode_t mode);
            if (req == REQ_TICK)
                advance_frame(pads, keys);
            else
                answers_due.push_back(answer_query(handle, mode));
        endfunction

        function int pending();
            return answers_due.size();
        endfunction

        task report_mismatch(string msg);
            if (errors < 40)
                $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(logic [ANSWER_W-1:0] got);
            logic [ANSWER_W-1:0] want;
            if (answers_due.size() == 0)
                report_mismatch($sformatf("answer %0d with no query outstanding",
                                          $signed(got)));
            else
            begin
                want = answers_due.pop_front();
                if (got !== want)
                    report_mismatch($sformatf("answer %0d, expected %0d",
                                              $signed(got), $signed(want)));
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Block ports, all inputs known from time zero
    // ------------------------------------------------------------------------
    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata  = '0;
    logic                   s_axis_tuser  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic                   cfg_valid     = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index     = '0;
    logic [CFG_DATA_W-1:0]  cfg_data      = '0;

    hold_scoreboard   sb;
    int               send_idle_pct  = 0;
    int               recv_stall_pct = 0;
    int               hold_off_left  = 0;
    logic [PAD_W-1:0] pad_held       = '0;
    logic [KEY_W-1:0] key_held       = '0;

    button_hold_trigger_toggle dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Free-running clock
    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Hard stop if the run hangs
    initial
    begin
        #(CLK_PERIOD * LIMIT_CYCLES);
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Answer side: check each accepted beat, then pick the next tready
    // ------------------------------------------------------------------------
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid === 1'b1 && m_axis_tready)
                sb.check_result(m_axis_tdata[ANSWER_W-1:0]);
            if (hold_off_left > 0)
            begin
                hold_off_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Request side tasks
    // ------------------------------------------------------------------------

    // Offer one beat after an optional gap, hold it until accepted
    task automatic send_item(logic req, logic [PAD_W-1:0] pads, logic [KEY_W-1:0] keys,
                             logic [HANDLE_W-1:0] handle, mode_t mode);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= S_TDATA_W'({mode, handle, keys, pads});
        do @(posedge clk); while (!s_axis_tready);
        sb.note_input(req, pads, keys, handle, mode);
    endtask

    // Mostly held buttons that change a few bits per frame, now and then a jump
    task automatic random_item();
        logic                req;
        logic [HANDLE_W-1:0] handle;
        mode_t               mode;
        req = ($urandom_range(99) < QUERY_PCT) ? REQ_QUERY : REQ_TICK;
        if ($urandom_range(19) == 0)
        begin
            pad_held = PAD_W'($urandom);
            key_held = KEY_W'($urandom);
        end
        else if (req == REQ_TICK)
        begin
            pad_held ^= PAD_W'($urandom & $urandom & $urandom);
            key_held ^= KEY_W'($urandom & $urandom & $urandom);
        end
        if ($urandom_range(99) < GOOD_HANDLE_PCT)
            handle = HANDLE_W'($urandom_range(PAD_SLOTS - 1));
        else
            handle = HANDLE_W'($urandom);
        mode = mode_t'($urandom_range(3));
        if (req == REQ_TICK)
            send_item(req, pad_held, key_held, handle, mode);
        else
            send_item(req, PAD_W'($urandom), KEY_W'($urandom), handle, mode);
    endtask

    // Drop valid and wait until every answer is back and the pipe is quiet
    task automatic drain_block();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(idx, value);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        sb = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed beats under reset config: every key merges into slot 0
        send_item(REQ_QUERY, '0, '0, 8'd0, MODE_PUSH);
        send_item(REQ_TICK, '1, '0, '1, MODE_ZERO);
        send_item(REQ_TICK, '1, '1, '0, MODE_PUSH);
        send_item(REQ_QUERY, '1, '1, 8'd0, MODE_PUSH);
        send_item(REQ_QUERY, '0, '0, 8'd15, MODE_PUSH);
        send_item(REQ_QUERY, '0, '0, 8'd5, MODE_TRIGGER);
        send_item(REQ_QUERY, '0, '0, 8'd15, MODE_TOGGLE);
        send_item(REQ_QUERY, '0, '0, 8'd5, MODE_TRIGGER);
        send_item(REQ_TICK, '0, '0, '0, MODE_PUSH);
        send_item(REQ_QUERY, '0, '0, 8'd5, MODE_TRIGGER);
        send_item(REQ_QUERY, '0, '0, 8'd5, MODE_TRIGGER);
        send_item(REQ_QUERY, '0, '0, 8'd15, MODE_TOGGLE);
        send_item(REQ_QUERY, '0, '0, 8'd16, MODE_PUSH);
        send_item(REQ_QUERY, '0, '0, 8'd255, MODE_TRIGGER);
        send_item(REQ_QUERY, '0, '0, 8'd200, MODE_TOGGLE);
        send_item(REQ_QUERY, '0, '0, 8'd255, MODE_ZERO);
        send_item(REQ_QUERY, '0, '0, 8'd3, MODE_ZERO);
        send_item(REQ_TICK, 16'h8000, 14'h2000, '0, MODE_PUSH);
        send_item(REQ_QUERY, '0, '0, 8'd0, MODE_PUSH);
        send_item(REQ_QUERY, '0, '0, 8'd15, MODE_TOGGLE);
        send_item(REQ_TICK, 16'h8000, 14'h2000, '0, MODE_PUSH);
        send_item(REQ_QUERY, '0, '0, 8'd15, MODE_TOGGLE);
        send_item(REQ_TICK, '0, '0, '0, MODE_PUSH);
        send_item(REQ_QUERY, '0, '0, 8'd15, MODE_TOGGLE);
        send_item(REQ_QUERY, '0, '0, 8'd0, MODE_PUSH);
        drain_block();

        // Writes to unused indexes must change nothing
        program_reg(CFG_SPARE_2, '1);
        program_reg(CFG_SPARE_3, CFG_DATA_W'({$urandom, $urandom}));

        // Random phases, each with its own setting and idling mix
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    program_reg(CFG_ACTION_MAP, '1);
                    program_reg(CFG_KEY_ENABLE, '1);
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    program_reg(CFG_ACTION_MAP, CFG_DATA_W'({$urandom, $urandom}));
                    program_reg(CFG_KEY_ENABLE, '0);
                    send_idle_pct  = 51;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    program_reg(CFG_ACTION_MAP, CFG_DATA_W'({$urandom, $urandom}));
                    program_reg(CFG_KEY_ENABLE, CFG_DATA_W'({$urandom, $urandom}));
                    send_idle_pct  = 0;
                    recv_stall_pct = 51;
                    hold_off_left  = LONG_HOLD_OFF;
                end
                default:
                begin
                    program_reg(CFG_ACTION_MAP, CFG_DATA_W'({$urandom, $urandom}));
                    program_reg(CFG_KEY_ENABLE, CFG_DATA_W'(KEY_ENABLE_RESET));
                    send_idle_pct  = 8;
                    recv_stall_pct = 8;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                random_item();
                // In phase 1, pause mid-phase until every answer is back
                if (phase == 1 && n == PHASE_ITEMS / 2)
                    drain_block();
            end
            drain_block();
        end

        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
